// ===== rtl/core/page_table_translate_with_permissions_unit_macros.svh =====
// Assertion macros shared by the page table translation unit.
// Each macro takes a label, an antecedent and a consequent; clk and rst_n
// must be visible where the macro is used.
`ifndef PAGE_TABLE_TRANSLATE_WITH_PERMISSIONS_UNIT_MACROS_SVH
`define PAGE_TABLE_TRANSLATE_WITH_PERMISSIONS_UNIT_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptt assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptt assertion failed");
`else
`define PTT_ASSERT_SAME(label, ante, cons)
`define PTT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/ptt_pkg.sv =====
package ptt_pkg;

  // Fixed field geometry
  localparam int VADDR_BITS  = 24;
  localparam int OFFSET_BITS = 12;
  localparam int PAGE_BITS   = 12;
  localparam int FRAME_IN_BITS = 8;
  localparam int BYTE_BITS   = 8;

  // Page table entry layout: {frame, read, write, present}
  localparam int PTE_PRESENT   = 0;
  localparam int PTE_WRITE     = 1;
  localparam int PTE_READ      = 2;
  localparam int PTE_FLAG_BITS = 3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_MAPPED   = 3'd1,
    STAT_ABSENT   = 3'd2,
    STAT_NO_READ  = 3'd3,
    STAT_NO_WRITE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR  = 2'd0,
    S_IDLE   = 2'd1,
    S_LOOKUP = 2'd2,
    S_DATA   = 2'd3
  } state_t;

endpackage

// ===== rtl/core/ptt_ram.sv =====
// Single-port synchronous RAM, registered read data held until the next read.
module ptt_ram #(
  parameter int AW = 12,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          re,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ptt_ctrl.sv =====
// Command sequencer: clearing pass, page entry lookup and update,
// data store access and the result register.
module ptt_ctrl #(
  parameter int VPN_BITS   = 12,
  parameter int FRAME_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_cmd,
  input  logic [ptt_pkg::PAGE_BITS-1:0]         in_page,
  input  logic [ptt_pkg::FRAME_IN_BITS-1:0]     in_frame,
  input  logic                                  in_allow_read,
  input  logic                                  in_allow_write,
  input  logic [ptt_pkg::VADDR_BITS-1:0]        in_vaddr,
  input  logic [ptt_pkg::BYTE_BITS-1:0]         in_write_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            out_status,
  output logic [ptt_pkg::BYTE_BITS-1:0]         out_read_data,
  // page table port
  output logic                                  pt_re,
  output logic                                  pt_we,
  output logic [VPN_BITS-1:0]                   pt_addr,
  output logic [FRAME_BITS+ptt_pkg::PTE_FLAG_BITS-1:0] pt_wdata,
  input  logic [FRAME_BITS+ptt_pkg::PTE_FLAG_BITS-1:0] pt_rdata,
  // data store port
  output logic                                  dm_re,
  output logic                                  dm_we,
  output logic [FRAME_BITS+ptt_pkg::OFFSET_BITS-1:0] dm_addr,
  output logic [ptt_pkg::BYTE_BITS-1:0]         dm_wdata,
  input  logic [ptt_pkg::BYTE_BITS-1:0]         dm_rdata
);

  localparam int DA_W  = FRAME_BITS + ptt_pkg::OFFSET_BITS;
  localparam int CLR_W = (VPN_BITS > DA_W) ? VPN_BITS : DA_W;

  ptt_pkg::state_t  state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // captured command
  ptt_pkg::cmd_t                    cmd_r;
  logic [VPN_BITS-1:0]              pidx_r;
  logic [FRAME_BITS-1:0]            frame_r;
  logic                             rd_r;
  logic                             wr_r;
  logic [ptt_pkg::OFFSET_BITS-1:0]  offs_r;
  logic [ptt_pkg::BYTE_BITS-1:0]    wdata_r;

  // result register
  logic                             out_valid_r, out_valid_nxt;
  ptt_pkg::status_t                 out_status_r;
  logic [ptt_pkg::BYTE_BITS-1:0]    out_rdata_r;

  logic                             in_fire;
  logic                             slot_free;
  ptt_pkg::cmd_t                    in_cmd_t;
  logic [VPN_BITS-1:0]              in_idx;
  logic                             e_present, e_write, e_read;
  logic [FRAME_BITS-1:0]            e_frame;
  ptt_pkg::status_t                 lk_status;
  logic                             rd_ok;
  logic                             res_load;
  ptt_pkg::status_t                 res_status;
  logic [ptt_pkg::BYTE_BITS-1:0]    res_rdata;

  assign in_cmd_t  = ptt_pkg::cmd_t'(in_cmd);
  assign in_ready  = (state_r == ptt_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // page index: explicit page for map commands, vaddr page part otherwise
  always_comb begin
    if (in_cmd_t == ptt_pkg::CMD_INSERT || in_cmd_t == ptt_pkg::CMD_REMOVE) begin
      in_idx = VPN_BITS'(in_page);
    end else begin
      in_idx = VPN_BITS'(in_vaddr[ptt_pkg::VADDR_BITS-1:ptt_pkg::OFFSET_BITS]);
    end
  end

  // entry decode
  assign e_present = pt_rdata[ptt_pkg::PTE_PRESENT];
  assign e_write   = pt_rdata[ptt_pkg::PTE_WRITE];
  assign e_read    = pt_rdata[ptt_pkg::PTE_READ];
  assign e_frame   = pt_rdata[ptt_pkg::PTE_FLAG_BITS +: FRAME_BITS];

  // lookup verdict
  always_comb begin
    lk_status = ptt_pkg::STAT_OK;
    unique case (cmd_r)
      ptt_pkg::CMD_INSERT: begin
        if (e_present) lk_status = ptt_pkg::STAT_MAPPED;
      end
      ptt_pkg::CMD_REMOVE: begin
        if (!e_present) lk_status = ptt_pkg::STAT_ABSENT;
      end
      ptt_pkg::CMD_READ: begin
        if (!e_present)   lk_status = ptt_pkg::STAT_ABSENT;
        else if (!e_read) lk_status = ptt_pkg::STAT_NO_READ;
      end
      ptt_pkg::CMD_WRITE: begin
        if (!e_present)    lk_status = ptt_pkg::STAT_ABSENT;
        else if (!e_write) lk_status = ptt_pkg::STAT_NO_WRITE;
      end
    endcase
  end

  assign rd_ok = (cmd_r == ptt_pkg::CMD_READ) && (lk_status == ptt_pkg::STAT_OK);

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ptt_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = ptt_pkg::S_IDLE;
      end
      ptt_pkg::S_IDLE: begin
        if (in_fire) state_nxt = ptt_pkg::S_LOOKUP;
      end
      ptt_pkg::S_LOOKUP: begin
        if (rd_ok)          state_nxt = ptt_pkg::S_DATA;
        else if (slot_free) state_nxt = ptt_pkg::S_IDLE;
      end
      ptt_pkg::S_DATA: begin
        if (slot_free) state_nxt = ptt_pkg::S_IDLE;
      end
    endcase
  end

  // memory controls and result load
  always_comb begin
    pt_re      = 1'b0;
    pt_we      = 1'b0;
    pt_addr    = pidx_r;
    pt_wdata   = '0;
    dm_re      = 1'b0;
    dm_we      = 1'b0;
    dm_addr    = {e_frame, offs_r};
    dm_wdata   = wdata_r;
    res_load   = 1'b0;
    res_status = lk_status;
    res_rdata  = '0;
    unique case (state_r)
      ptt_pkg::S_CLEAR: begin
        pt_we    = 1'b1;
        pt_addr  = clr_cnt_r[VPN_BITS-1:0];
        dm_we    = 1'b1;
        dm_addr  = clr_cnt_r[DA_W-1:0];
        dm_wdata = '0;
      end
      ptt_pkg::S_IDLE: begin
        pt_re   = in_fire;
        pt_addr = in_idx;
      end
      ptt_pkg::S_LOOKUP: begin
        if (rd_ok) begin
          dm_re = 1'b1;
        end else if (slot_free) begin
          res_load = 1'b1;
          unique case (cmd_r)
            ptt_pkg::CMD_INSERT: begin
              pt_we    = !e_present;
              pt_wdata = {frame_r, rd_r, wr_r, 1'b1};
            end
            ptt_pkg::CMD_REMOVE: pt_we = e_present;
            ptt_pkg::CMD_READ:   ;
            ptt_pkg::CMD_WRITE:  dm_we = (lk_status == ptt_pkg::STAT_OK);
          endcase
        end
      end
      ptt_pkg::S_DATA: begin
        res_load   = slot_free;
        res_status = ptt_pkg::STAT_OK;
        res_rdata  = dm_rdata;
      end
    endcase
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptt_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd_t;
      pidx_r  <= in_idx;
      frame_r <= FRAME_BITS'(in_frame);
      rd_r    <= in_allow_read;
      wr_r    <= in_allow_write;
      offs_r  <= in_vaddr[ptt_pkg::OFFSET_BITS-1:0];
      wdata_r <= in_write_data;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_rdata_r  <= res_rdata;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_rdata_r;

endmodule

// ===== rtl/core/page_table_translate_with_permissions_unit.sv =====
// Page table translation unit with read/write permissions. Each command
// transfer (insert, remove, read byte, write byte) yields exactly one result
// transfer. After reset the unit runs a clearing pass over the page table and
// the data store together, one entry per cycle; in_ready stays low until it
// ends. Afterwards a command is taken in IDLE and its page entry is read from
// the page table RAM at the accepting edge. The entry update or data store
// write is done in LOOKUP once the result slot is free. A successful read
// needs a second dependent access to the data store RAM, done in DATA.
// A result held on out_* while out_ready is low stalls the unit before its
// memory writes, so nothing is lost or applied twice.
`include "page_table_translate_with_permissions_unit_macros.svh"

module page_table_translate_with_permissions_unit #(
  parameter int VPN_BITS   = 12,
  parameter int FRAME_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [ptt_pkg::PAGE_BITS-1:0]     in_page,
  input  logic [ptt_pkg::FRAME_IN_BITS-1:0] in_frame,
  input  logic                              in_allow_read,
  input  logic                              in_allow_write,
  input  logic [ptt_pkg::VADDR_BITS-1:0]    in_vaddr,
  input  logic [ptt_pkg::BYTE_BITS-1:0]     in_write_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [ptt_pkg::BYTE_BITS-1:0]     out_read_data
);

  localparam int PTE_W = FRAME_BITS + ptt_pkg::PTE_FLAG_BITS;
  localparam int DA_W  = FRAME_BITS + ptt_pkg::OFFSET_BITS;

  logic                          pt_re, pt_we;
  logic [VPN_BITS-1:0]           pt_addr;
  logic [PTE_W-1:0]              pt_wdata, pt_rdata;
  logic                          dm_re, dm_we;
  logic [DA_W-1:0]               dm_addr;
  logic [ptt_pkg::BYTE_BITS-1:0] dm_wdata, dm_rdata;

  // sequencer
  ptt_ctrl #(
    .VPN_BITS   (VPN_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_page        (in_page),
    .in_frame       (in_frame),
    .in_allow_read  (in_allow_read),
    .in_allow_write (in_allow_write),
    .in_vaddr       (in_vaddr),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .pt_re          (pt_re),
    .pt_we          (pt_we),
    .pt_addr        (pt_addr),
    .pt_wdata       (pt_wdata),
    .pt_rdata       (pt_rdata),
    .dm_re          (dm_re),
    .dm_we          (dm_we),
    .dm_addr        (dm_addr),
    .dm_wdata       (dm_wdata),
    .dm_rdata       (dm_rdata)
  );

  // page table, one entry per virtual page
  ptt_ram #(
    .AW (VPN_BITS),
    .DW (PTE_W)
  ) u_pt_ram (
    .clk   (clk),
    .re    (pt_re),
    .we    (pt_we),
    .addr  (pt_addr),
    .wdata (pt_wdata),
    .rdata (pt_rdata)
  );

  // physical byte store
  ptt_ram #(
    .AW (DA_W),
    .DW (ptt_pkg::BYTE_BITS)
  ) u_data_ram (
    .clk   (clk),
    .re    (dm_re),
    .we    (dm_we),
    .addr  (dm_addr),
    .wdata (dm_wdata),
    .rdata (dm_rdata)
  );

  // checks
  `PTT_ASSERT_SAME(a_pt_rw_excl, pt_we, !pt_re)
  `PTT_ASSERT_SAME(a_dm_rw_excl, dm_we, !dm_re)
  `PTT_ASSERT_SAME(a_no_write_on_accept, pt_we || dm_we, !(in_valid && in_ready))
  `PTT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule
